[hdl/tms_pkg.sv]
// ----------------------------------------------------------------------------
// tms_pkg: shared types and constants for the tone melody sequencer
// Sizes, command and phase codes, controller states, control/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package tms_pkg;

  localparam int TABLE_DEPTH    = 256;
  localparam int QUEUE_DEPTH    = 4;
  localparam int TIMER_CLOCK_HZ = 1000000;

  localparam int CMD_W      = 3;
  localparam int NOTE_IDX_W = 8;
  localparam int COUNT_W    = 9;
  localparam int FREQ_W     = 16;
  localparam int MS_W       = 16;
  localparam int RELOAD_W   = 20;
  localparam int COMPARE_W  = 19;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int ENTRY_W    = FREQ_W + 2 * MS_W;
  localparam int TONE_W     = FREQ_W + MS_W;

  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int QSUM_W = FILL_W + 1;

  // divider: constant dividend, one quotient bit per cycle
  localparam int QUOT_W    = $clog2(TIMER_CLOCK_HZ + 1);
  localparam int DIV_CNT_W = $clog2(QUOT_W);

  localparam logic [COUNT_W-1:0] NOTE_COUNT_RST = COUNT_W'(1);
  localparam logic [MS_W-1:0]    LOOP_GAP_RST   = MS_W'(1000);
  localparam logic [MS_W-1:0]    TONE_GAP_RST   = MS_W'(20);

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 3'd0,
    CMD_WRITE = 3'd1,
    CMD_START = 3'd2,
    CMD_STOP  = 3'd3,
    CMD_QUEUE = 3'd4
  } cmd_e_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NOTE_COUNT  = 2'd0,
    REG_LOOP_ENABLE = 2'd1,
    REG_LOOP_GAP    = 2'd2,
    REG_TONE_GAP    = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_TONE       = 3'd1,
    PH_TONE_GAP   = 3'd2,
    PH_NOTE       = 3'd3,
    PH_NOTE_PAUSE = 3'd4,
    PH_LOOP_GAP   = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    CT_IDLE,
    CT_DECODE,
    CT_WAIT,
    CT_SETTLE,
    CT_DIV,
    CT_RESULT
  } ctl_state_t;

  typedef struct packed {
    logic capture;
    logic tick;
    logic mem_wr;
    logic start;
    logic stop;
    logic enqueue;
    logic finish;
    logic dispatch;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic phase_idle;
    logic rem_zero;
    logic can_dispatch;
    logic disp_sounds;
    logic div_done;
    logic out_busy;
  } dp_sts_t;

endpackage

`default_nettype wire

[hdl/tms_if.sv]
// ----------------------------------------------------------------------------
// tms_if: channel interfaces of the tone melody sequencer
// Input item, result item and configuration write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface tms_in_if import tms_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [NOTE_IDX_W-1:0] index;
  logic [FREQ_W-1:0] frequency;
  logic [MS_W-1:0]   duration;
  logic [MS_W-1:0]   pause;

  modport source (output valid, cmd, index, frequency, duration, pause, input ready);
  modport sink   (input valid, cmd, index, frequency, duration, pause, output ready);
endinterface

interface tms_out_if import tms_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic                  pwm_on;
  logic [RELOAD_W-1:0]   pwm_reload;
  logic [COMPARE_W-1:0]  pwm_compare;
  logic                  playing;
  logic                  looping;
  logic [NOTE_IDX_W-1:0] note_position;
  logic                  tone_dropped;

  modport source (output valid, pwm_on, pwm_reload, pwm_compare, playing, looping,
                  note_position, tone_dropped, input ready);
  modport sink   (input valid, pwm_on, pwm_reload, pwm_compare, playing, looping,
                  note_position, tone_dropped, output ready);
endinterface

interface tms_cfg_if import tms_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hdl/tone_melody_sequencer_top.sv]
// ----------------------------------------------------------------------------
// tone_melody_sequencer_top: buzzer melody player with one-off tone queue
// Plays a note table track driven by 1 ms tick items; queued tones preempt
// the next track note. Each item yields one result item with the PWM setup.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake          carries
//   in_ch    in   valid/ready        cmd, index, frequency, duration, pause
//   out_ch   out  valid/ready        pwm_on, pwm_reload, pwm_compare, playing,
//                                    looping, note_position, tone_dropped
//   cfg_ch   in   valid/ready(=1)    index, data (note_count, loop_enable,
//                                    loop_gap_ms, tone_gap_ms)
//
// Sequence: one item at a time. Write, start, stop, queue and unused codes pass
//   accept, decode and result steps. A tick also takes a table read wait and a
//   settle step for each segment closed or started, and a divider wait when a
//   sounding tone or note starts: the period divider resolves one quotient bit
//   per cycle.
// Reset: synchronous, active low; control, config and timer values cleared.
//   The note table and tone queue are not cleared (undefined until written).
// Stalls: the result register holds one item; the next item is taken while it
//   waits, and the block only stalls if a second result is ready before then.
// ----------------------------------------------------------------------------
`default_nettype none

module tone_melody_sequencer_top import tms_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  tms_in_if.sink    in_ch,
  tms_out_if.source out_ch,
  tms_cfg_if.sink   cfg_ch
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;
  logic    in_ready;

  assign in_ch.ready = in_ready;

  // sequencing: item decode, segment steps, divider wait, result handoff
  tms_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .cmd      (dp_cmd),
    .sts      (dp_sts)
  );

  // storage, timers and result register
  tms_dpath u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (dp_cmd),
    .sts          (dp_sts),
    .in_cmd       (in_ch.cmd),
    .in_index     (in_ch.index),
    .in_frequency (in_ch.frequency),
    .in_duration  (in_ch.duration),
    .in_pause     (in_ch.pause),
    .cfg_ch       (cfg_ch),
    .out_ch       (out_ch)
  );

  // a segment is only closed once its time is used up
  a_finish_ok: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.finish |-> (!dp_sts.phase_idle && dp_sts.rem_zero))
    else $error("segment closed while idle or time remaining");

  // a new tone or note only starts from idle with something to play
  a_dispatch_ok: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.dispatch |-> (dp_sts.phase_idle && dp_sts.can_dispatch))
    else $error("dispatch while busy or with nothing to play");

  // one item at a time: no back-to-back accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted while previous item in work");

  // looping is only reported on an active track
  a_loop_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (!out_ch.looping || out_ch.playing))
    else $error("looping reported without an active track");

endmodule

`default_nettype wire

[hdl/tms_div.sv]
// ----------------------------------------------------------------------------
// tms_div: timer period divider
// Restoring division of the timer clock by a frequency, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tms_div import tms_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [FREQ_W-1:0] divisor,
  output logic                   done,
  output logic [QUOT_W-1:0]      quotient
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [FREQ_W-1:0]    rem_r, rem_nxt;
  logic [FREQ_W-1:0]    dsr_r, dsr_nxt;
  logic [QUOT_W-1:0]    quo_r, quo_nxt;
  logic [FREQ_W:0]      trial;
  logic [FREQ_W:0]      diff;

  assign trial = {rem_r, quo_r[QUOT_W-1]};
  assign diff  = trial - {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      quo_nxt  = QUOT_W'(TIMER_CLOCK_HZ);  // dividend shifts out as quotient shifts in
    end else if (busy_r) begin
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = diff[FREQ_W-1:0];
        quo_nxt = {quo_r[QUOT_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[FREQ_W-1:0];
        quo_nxt = {quo_r[QUOT_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(QUOT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

[hdl/tms_ctrl.sv]
// ----------------------------------------------------------------------------
// tms_ctrl: sequencer control state machine
// Takes an item, walks the datapath through its segment steps, posts result.
// ----------------------------------------------------------------------------
`default_nettype none

module tms_ctrl import tms_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  output dp_cmd_t      cmd,
  input  wire dp_sts_t sts
);

  ctl_state_t state_r, state_nxt;
  logic       dispatched_r, dispatched_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= CT_IDLE;
      dispatched_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      dispatched_r <= dispatched_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    dispatched_nxt = dispatched_r;
    cmd            = '0;
    in_ready       = 1'b0;
    case (state_r)
      CT_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) state_nxt = CT_DECODE;
      end
      CT_DECODE: begin
        dispatched_nxt = 1'b0;
        state_nxt      = CT_RESULT;
        case (sts.cmd)
          CMD_TICK: begin
            cmd.tick  = 1'b1;
            state_nxt = CT_WAIT;
          end
          CMD_WRITE: cmd.mem_wr  = 1'b1;
          CMD_START: cmd.start   = 1'b1;
          CMD_STOP:  cmd.stop    = 1'b1;
          CMD_QUEUE: cmd.enqueue = 1'b1;
          default: ;
        endcase
      end
      // wait state for the registered table read at the current note
      CT_WAIT: state_nxt = CT_SETTLE;
      CT_SETTLE: begin
        if (!sts.phase_idle && sts.rem_zero) begin
          cmd.finish = 1'b1;
          state_nxt  = CT_WAIT;
        end else if (sts.phase_idle && !dispatched_r && sts.can_dispatch) begin
          cmd.dispatch   = 1'b1;
          dispatched_nxt = 1'b1;
          state_nxt      = sts.disp_sounds ? CT_DIV : CT_WAIT;
        end else begin
          state_nxt = CT_RESULT;
        end
      end
      CT_DIV: if (sts.div_done) state_nxt = CT_WAIT;
      CT_RESULT: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = CT_IDLE;
        end
      end
      default: state_nxt = CT_IDLE;
    endcase
  end

endmodule

`default_nettype wire

[hdl/tms_dpath.sv]
// ----------------------------------------------------------------------------
// tms_dpath: sequencer datapath
// Note table, tone queue, segment timer, config registers, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tms_dpath import tms_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire dp_cmd_t               cmd,
  output dp_sts_t                    sts,
  input  wire logic [CMD_W-1:0]      in_cmd,
  input  wire logic [NOTE_IDX_W-1:0] in_index,
  input  wire logic [FREQ_W-1:0]     in_frequency,
  input  wire logic [MS_W-1:0]       in_duration,
  input  wire logic [MS_W-1:0]       in_pause,
  tms_cfg_if.sink                    cfg_ch,
  tms_out_if.source                  out_ch
);

  localparam logic [COUNT_W-1:0] TRACK_MAX = COUNT_W'(TABLE_DEPTH);

  // configuration
  logic [COUNT_W-1:0] note_count_r;
  logic               loop_en_r;
  logic [MS_W-1:0]    loop_gap_r;
  logic [MS_W-1:0]    tone_gap_r;

  // captured item
  logic [CMD_W-1:0]      item_cmd_r;
  logic [NOTE_IDX_W-1:0] item_idx_r;
  logic [FREQ_W-1:0]     item_freq_r;
  logic [MS_W-1:0]       item_dur_r;
  logic [MS_W-1:0]       item_pause_r;

  // storage
  logic [ENTRY_W-1:0] note_mem [TABLE_DEPTH];
  logic [ENTRY_W-1:0] entry_r;
  logic [TONE_W-1:0]  tone_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  head_r;
  logic [FILL_W-1:0]  fill_r;

  // playback state
  phase_t                phase_r;
  logic [MS_W-1:0]       rem_r;
  logic [NOTE_IDX_W-1:0] cur_note_r;
  logic                  active_r;
  logic                  loops_r;
  logic                  sounding_r;
  logic [RELOAD_W-1:0]   reload_r;
  logic [COMPARE_W-1:0]  compare_r;
  logic                  dropped_r;
  logic                  out_valid_r;

  logic [QSUM_W-1:0]     tail_sum;
  logic [QPTR_W-1:0]     tail;
  logic [QPTR_W-1:0]     head_inc;
  logic [TONE_W-1:0]     head_tone;
  logic                  q_empty;
  logic                  q_full;
  logic [FREQ_W-1:0]     disp_freq;
  logic [MS_W-1:0]       disp_dur;
  logic [COUNT_W-1:0]    track_len;
  logic [COUNT_W-1:0]    next_note;
  logic                  last_note;
  logic                  div_start;
  logic                  div_done;
  logic [QUOT_W-1:0]     period;

  assign q_empty   = (fill_r == '0);
  assign q_full    = (fill_r == FILL_W'(QUEUE_DEPTH));
  assign tail_sum  = QSUM_W'(head_r) + QSUM_W'(fill_r);
  assign tail      = (tail_sum >= QSUM_W'(QUEUE_DEPTH)) ?
                     QPTR_W'(tail_sum - QSUM_W'(QUEUE_DEPTH)) : QPTR_W'(tail_sum);
  assign head_inc  = (head_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign head_tone = tone_q[head_r];

  // queued tones win over the track note
  assign disp_freq = q_empty ? entry_r[FREQ_W-1:0] : head_tone[FREQ_W-1:0];
  assign disp_dur  = q_empty ? entry_r[FREQ_W +: MS_W] : head_tone[FREQ_W +: MS_W];

  assign track_len = (note_count_r > TRACK_MAX) ? TRACK_MAX : note_count_r;
  assign next_note = COUNT_W'(cur_note_r) + 1'b1;
  assign last_note = (next_note >= track_len);
  assign div_start = cmd.dispatch && (disp_freq != '0);

  tms_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (disp_freq),
    .done     (div_done),
    .quotient (period)
  );

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      note_count_r <= NOTE_COUNT_RST;
      loop_en_r    <= 1'b0;
      loop_gap_r   <= LOOP_GAP_RST;
      tone_gap_r   <= TONE_GAP_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_NOTE_COUNT:  note_count_r <= cfg_ch.data[COUNT_W-1:0];
        REG_LOOP_ENABLE: loop_en_r    <= cfg_ch.data[0];
        REG_LOOP_GAP:    loop_gap_r   <= cfg_ch.data[MS_W-1:0];
        REG_TONE_GAP:    tone_gap_r   <= cfg_ch.data[MS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_cmd_r   <= in_cmd;
      item_idx_r   <= in_index;
      item_freq_r  <= in_frequency;
      item_dur_r   <= in_duration;
      item_pause_r <= in_pause;
    end
  end

  // note table: one write port, registered read at the current note
  always_ff @(posedge clk) begin
    if (cmd.mem_wr && (COUNT_W'(item_idx_r) < TRACK_MAX))
      note_mem[item_idx_r] <= {item_pause_r, item_dur_r, item_freq_r};
    entry_r <= note_mem[cur_note_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.enqueue && !q_full)
      tone_q[tail] <= {item_dur_r, item_freq_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      fill_r      <= '0;
      phase_r     <= PH_IDLE;
      rem_r       <= '0;
      cur_note_r  <= '0;
      active_r    <= 1'b0;
      loops_r     <= 1'b0;
      sounding_r  <= 1'b0;
      reload_r    <= '0;
      compare_r   <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.capture) dropped_r <= 1'b0;

      if (cmd.enqueue) begin
        if (q_full) dropped_r <= 1'b1;
        else        fill_r    <= fill_r + 1'b1;
      end

      if (cmd.tick && (phase_r != PH_IDLE) && (rem_r != '0))
        rem_r <= rem_r - 1'b1;

      // start and stop only cut track segments; a tone and its gap go on
      if (cmd.start || cmd.stop) begin
        active_r   <= cmd.start;
        loops_r    <= cmd.start && loop_en_r;
        cur_note_r <= '0;
        if (phase_r inside {PH_NOTE, PH_NOTE_PAUSE, PH_LOOP_GAP}) begin
          phase_r    <= PH_IDLE;
          rem_r      <= '0;
          sounding_r <= 1'b0;
        end
      end

      if (cmd.finish) begin
        case (phase_r)
          PH_TONE: begin
            sounding_r <= 1'b0;
            phase_r    <= PH_TONE_GAP;
            rem_r      <= tone_gap_r;
          end
          PH_NOTE: begin
            sounding_r <= 1'b0;
            phase_r    <= PH_NOTE_PAUSE;
            rem_r      <= entry_r[FREQ_W + MS_W +: MS_W];
          end
          PH_NOTE_PAUSE: begin
            phase_r <= PH_IDLE;
            if (!last_note) begin
              cur_note_r <= next_note[NOTE_IDX_W-1:0];
            end else if (loops_r) begin
              cur_note_r <= '0;
              phase_r    <= PH_LOOP_GAP;
              rem_r      <= loop_gap_r;
            end else begin
              active_r   <= 1'b0;
              loops_r    <= 1'b0;
              cur_note_r <= '0;
              rem_r      <= '0;
              sounding_r <= 1'b0;
            end
          end
          default: begin
            phase_r    <= PH_IDLE;
            sounding_r <= 1'b0;
          end
        endcase
      end

      if (cmd.dispatch) begin
        phase_r    <= q_empty ? PH_NOTE : PH_TONE;
        rem_r      <= disp_dur;
        sounding_r <= (disp_freq != '0);
        if (!q_empty) begin
          head_r <= head_inc;
          fill_r <= fill_r - 1'b1;
        end
      end

      if (div_done) begin
        reload_r  <= (period == '0) ? '0 : RELOAD_W'(period - 1'b1);
        compare_r <= COMPARE_W'(period >> 1);
      end

      if (cmd.load_out)         out_valid_r <= 1'b1;
      else if (out_ch.ready)    out_valid_r <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_ch.pwm_on        <= sounding_r;
      out_ch.pwm_reload    <= reload_r;
      out_ch.pwm_compare   <= compare_r;
      out_ch.playing       <= active_r;
      out_ch.looping       <= active_r && loops_r;
      out_ch.note_position <= cur_note_r;
      out_ch.tone_dropped  <= dropped_r;
    end
  end

  assign out_ch.valid = out_valid_r;

  assign sts.cmd          = item_cmd_r;
  assign sts.phase_idle   = (phase_r == PH_IDLE);
  assign sts.rem_zero     = (rem_r == '0);
  assign sts.can_dispatch = !q_empty || active_r;
  assign sts.disp_sounds  = (disp_freq != '0);
  assign sts.div_done     = div_done;
  assign sts.out_busy     = out_valid_r && !out_ch.ready;

endmodule

`default_nettype wire
